/* design/orpa_pkg.sv */
// Shared types, constants and the control store of the orbital-rate pitch accumulator.
package orpa_pkg;

  // Register and field widths fixed by the block's definition.
  localparam int BODY_BITS     = 2;
  localparam int ALT_BITS      = 10;
  localparam int SLEW_BITS     = 2;
  localparam int PITCH_BITS    = 32;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = ALT_BITS;

  // Orbit constants in units of 1e-6, so that D = K0 + K1 * altitude.
  localparam int K0_BITS = 22;
  localparam int K1_BITS = 13;
  localparam int D_BITS  = 24;
  localparam int DIV_BITS = 35;
  localparam int SCALE_BITS = 11;
  localparam logic [K0_BITS-1:0]    EARTH_K0   = 22'd2818200;
  localparam logic [K1_BITS-1:0]    EARTH_K1   = 13'd1265;
  localparam logic [K0_BITS-1:0]    MOON_K0    = 22'd3584700;
  localparam logic [K1_BITS-1:0]    MOON_K1    = 13'd6342;
  localparam logic [SCALE_BITS-1:0] RATE_SCALE = 11'd1800;

  // The quotient carries eight extra bits for the 256x term and one for rounding.
  localparam int FAST_SHIFT  = 8;
  localparam int SLOW_SHIFT  = 4;
  localparam int QUO_GUARD   = FAST_SHIFT + 1;

  typedef enum logic [BODY_BITS-1:0] {
    BODY_OFF   = 2'd0,
    BODY_EARTH = 2'd1,
    BODY_MOON  = 2'd2
  } body_e;

  typedef enum logic [SLEW_BITS-1:0] {
    SLEW_NONE = 2'd0,
    SLEW_UP   = 2'd1,
    SLEW_DOWN = 2'd2
  } slew_e;

  typedef enum logic {
    MODE_OPERATE = 1'b0,
    MODE_HOLD    = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BODY_SELECT = 1'b0,
    CFG_ALTITUDE    = 1'b1
  } cfg_reg_e;

  // Datapath operations, one per control word.
  typedef enum logic [2:0] {
    OP_LATCH    = 3'd0,
    OP_MUL_K1   = 3'd1,
    OP_ADD_K0   = 3'd2,
    OP_SCALE    = 3'd3,
    OP_DIV_STEP = 3'd4,
    OP_ACC_RATE = 3'd5,
    OP_ACC_SLEW = 3'd6,
    OP_EMIT     = 3'd7
  } uop_e;

  // What a step waits for before it executes and moves on.
  typedef enum logic [1:0] {
    GATE_NONE = 2'd0,
    GATE_IN   = 2'd1,
    GATE_OUT  = 2'd2
  } gate_e;

  typedef enum logic [1:0] {
    COND_NEXT     = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_OFF      = 2'd2,
    COND_DIV_MORE = 2'd3
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_LATCH = 3'd0;
  localparam step_t STEP_MUL   = 3'd1;
  localparam step_t STEP_ADD   = 3'd2;
  localparam step_t STEP_SCALE = 3'd3;
  localparam step_t STEP_DIV   = 3'd4;
  localparam step_t STEP_RATE  = 3'd5;
  localparam step_t STEP_SLEW  = 3'd6;
  localparam step_t STEP_EMIT  = 3'd7;

  typedef struct packed {
    uop_e  op;
    gate_e gate;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    uop_e op;
    logic fire;
  } orpa_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic powered;
    logic div_more;
  } orpa_stat_t;

  // The program: latch a tick, build the divisor, divide one bit per step,
  // apply the rate and slew terms, then present the result; an unpowered tick skips to the result.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      STEP_LATCH: w = '{op: OP_LATCH,    gate: GATE_IN,   cond: COND_NEXT,     target: STEP_LATCH};
      STEP_MUL:   w = '{op: OP_MUL_K1,   gate: GATE_NONE, cond: COND_OFF,      target: STEP_EMIT};
      STEP_ADD:   w = '{op: OP_ADD_K0,   gate: GATE_NONE, cond: COND_NEXT,     target: STEP_LATCH};
      STEP_SCALE: w = '{op: OP_SCALE,    gate: GATE_NONE, cond: COND_NEXT,     target: STEP_LATCH};
      STEP_DIV:   w = '{op: OP_DIV_STEP, gate: GATE_NONE, cond: COND_DIV_MORE, target: STEP_DIV};
      STEP_RATE:  w = '{op: OP_ACC_RATE, gate: GATE_NONE, cond: COND_NEXT,     target: STEP_LATCH};
      STEP_SLEW:  w = '{op: OP_ACC_SLEW, gate: GATE_NONE, cond: COND_NEXT,     target: STEP_LATCH};
      STEP_EMIT:  w = '{op: OP_EMIT,     gate: GATE_OUT,  cond: COND_ALWAYS,   target: STEP_LATCH};
      default:    w = '{op: OP_LATCH,    gate: GATE_IN,   cond: COND_NEXT,     target: STEP_LATCH};
    endcase
    return w;
  endfunction

endpackage

/* design/orpa_if.sv */
// Channel interfaces of the orbital-rate pitch accumulator: tick, result and configuration.
interface orpa_tick_if #(
  parameter int TICK_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] tick_microseconds;
  logic                 ac_power_ok;
  logic                 dc_power_ok;
  logic                 mode;
  logic [1:0]           slew_direction;
  logic                 indicator_one_enable;
  logic                 indicator_two_enable;

  modport source (
    output valid, tick_microseconds, ac_power_ok, dc_power_ok, mode, slew_direction,
           indicator_one_enable, indicator_two_enable,
    input  ready
  );
  modport sink (
    input  valid, tick_microseconds, ac_power_ok, dc_power_ok, mode, slew_direction,
           indicator_one_enable, indicator_two_enable,
    output ready
  );
endinterface

interface orpa_pitch_if ();
  logic        valid;
  logic        ready;
  logic [31:0] indicator_one_pitch;
  logic [31:0] indicator_two_pitch;

  modport source (output valid, indicator_one_pitch, indicator_two_pitch, input ready);
  modport sink (input valid, indicator_one_pitch, indicator_two_pitch, output ready);
endinterface

interface orpa_cfg_if import orpa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/orpa_sequencer.sv */
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module orpa_sequencer import orpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  orpa_stat_t stat_i,
  output orpa_ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  ucode_t word;
  logic   go;
  logic   jump;

  assign word = ucode_rom(step_q);

  // A step executes only once whatever it waits for is there.
  always_comb begin
    unique case (word.gate)
      GATE_NONE: go = 1'b1;
      GATE_IN:   go = stat_i.in_valid;
      GATE_OUT:  go = stat_i.out_free;
      default:   go = 1'b0;
    endcase
    unique case (word.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_OFF:      jump = !stat_i.powered;
      COND_DIV_MORE: jump = stat_i.div_more;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = jump ? word.target : step_q + step_t'(1);
    end
  end

  always_comb begin
    ctrl_o.op   = word.op;
    ctrl_o.fire = go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LATCH;
    end else begin
      step_q <= step_d;
    end
  end

  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.fire && ctrl_o.op == OP_EMIT) |=> ctrl_o.op == OP_LATCH)
    else $error("sequencer did not return to the latch step after a result");

  a_off_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == OP_MUL_K1 && !stat_i.powered) |=> ctrl_o.op == OP_EMIT)
    else $error("unpowered tick did not skip to the result step");

endmodule

/* design/orpa_datapath.sv */
// Datapath: divisor build, restoring divider, rounding and the pitch angle register.
module orpa_datapath import orpa_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int TICK_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  orpa_ctrl_t            ctrl_i,
  input  logic [BODY_BITS-1:0]  body_select_i,
  input  logic [ALT_BITS-1:0]   altitude_setting_i,
  input  logic [TICK_BITS-1:0]  tick_microseconds_i,
  input  logic                  ac_power_ok_i,
  input  logic                  dc_power_ok_i,
  input  logic                  mode_i,
  input  logic [SLEW_BITS-1:0]  slew_direction_i,
  input  logic                  indicator_one_enable_i,
  input  logic                  indicator_two_enable_i,
  output logic                  powered_o,
  output logic                  div_more_o,
  output logic [PITCH_BITS-1:0] indicator_one_pitch_o,
  output logic [PITCH_BITS-1:0] indicator_two_pitch_o
);

  // Dividend is tick << (ANGLE_BITS + QUO_GUARD), fed one bit per step.
  localparam int NUM_BITS = TICK_BITS + ANGLE_BITS + QUO_GUARD;
  localparam int Q_BITS   = ANGLE_BITS + QUO_GUARD;
  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic [TICK_BITS-1:0]  t_q;
  logic                  ac_q, dc_q, hold_q, en1_q, en2_q;
  logic [SLEW_BITS-1:0]  slew_q;
  logic [D_BITS-1:0]     prod_q, prod_d;
  logic [DIV_BITS-1:0]   div_q, div_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [Q_BITS-1:0]     quo_q, quo_d;
  logic [TICK_BITS-1:0]  num_q, num_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [ANGLE_BITS-1:0] angle_q, angle_d;

  logic                  body_on;
  logic [K1_BITS-1:0]    k1_sel;
  logic [K0_BITS-1:0]    k0_sel;
  logic [DIV_BITS:0]     trial;
  logic                  trial_ge;
  logic [ANGLE_BITS-1:0] term_1x, term_16x, term_256x, slew_term;
  logic [PITCH_BITS-1:0] angle_out;
  logic                  latch_en;

  // Round half up: floor(2x) is the quotient with one more bit.
  function automatic logic [ANGLE_BITS-1:0] round_half(input logic [ANGLE_BITS:0] x);
    logic [ANGLE_BITS+1:0] r;
    r = {1'b0, x} + (ANGLE_BITS+2)'(1);
    return r[ANGLE_BITS:1];
  endfunction

  assign body_on    = (body_select_i == BODY_EARTH) || (body_select_i == BODY_MOON);
  assign powered_o  = body_on && ac_q && dc_q;
  assign div_more_o = (cnt_q != '0);
  assign k1_sel     = (body_select_i == BODY_MOON) ? MOON_K1 : EARTH_K1;
  assign k0_sel     = (body_select_i == BODY_MOON) ? MOON_K0 : EARTH_K0;

  assign trial    = {rem_q, num_q[TICK_BITS-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  assign term_1x   = round_half(quo_q[ANGLE_BITS+FAST_SHIFT:FAST_SHIFT]);
  assign term_16x  = round_half(quo_q[ANGLE_BITS+SLOW_SHIFT:SLOW_SHIFT]);
  assign term_256x = round_half(quo_q[ANGLE_BITS:0]);
  assign slew_term = (hold_q == MODE_HOLD) ? term_256x : term_16x;

  assign latch_en = ctrl_i.fire && (ctrl_i.op == OP_LATCH);

  always_comb begin
    prod_d  = prod_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    num_d   = num_q;
    cnt_d   = cnt_q;
    angle_d = angle_q;
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        OP_MUL_K1: prod_d = D_BITS'(k1_sel) * D_BITS'(altitude_setting_i);
        OP_ADD_K0: prod_d = prod_q + D_BITS'(k0_sel);
        OP_SCALE: begin
          div_d = DIV_BITS'(prod_q) * DIV_BITS'(RATE_SCALE);
          rem_d = '0;
          quo_d = '0;
          num_d = t_q;
          cnt_d = CNT_BITS'(NUM_BITS - 1);
        end
        OP_DIV_STEP: begin
          rem_d = trial_ge ? DIV_BITS'(trial - {1'b0, div_q}) : trial[DIV_BITS-1:0];
          quo_d = {quo_q[Q_BITS-2:0], trial_ge};
          num_d = num_q << 1;
          cnt_d = cnt_q - CNT_BITS'(1);
        end
        OP_ACC_RATE: begin
          if (hold_q == MODE_OPERATE) begin
            angle_d = angle_q + term_1x;
          end
        end
        OP_ACC_SLEW: begin
          if (slew_q == SLEW_UP) begin
            angle_d = angle_q + slew_term;
          end else if (slew_q == SLEW_DOWN) begin
            angle_d = angle_q - slew_term;
          end
        end
        default: begin
        end
      endcase
    end
  end

  generate
    if (ANGLE_BITS >= PITCH_BITS) begin : g_out_trunc
      assign angle_out = angle_q[ANGLE_BITS-1 -: PITCH_BITS];
    end else begin : g_out_pad
      assign angle_out = {angle_q, {(PITCH_BITS-ANGLE_BITS){1'b0}}};
    end
  endgenerate

  assign indicator_one_pitch_o = (powered_o && en1_q) ? angle_out : '0;
  assign indicator_two_pitch_o = (powered_o && en2_q) ? angle_out : '0;

  always_ff @(posedge clk_i) begin
    if (latch_en) begin
      t_q    <= tick_microseconds_i;
      ac_q   <= ac_power_ok_i;
      dc_q   <= dc_power_ok_i;
      hold_q <= mode_i;
      slew_q <= slew_direction_i;
      en1_q  <= indicator_one_enable_i;
      en2_q  <= indicator_two_enable_i;
    end
    prod_q <= prod_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    num_q  <= num_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      angle_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      angle_q <= angle_d;
    end
  end

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && ctrl_i.op == OP_DIV_STEP) |-> rem_q < div_q)
    else $error("divider remainder not below the divisor");

  a_angle_only_on_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.fire && (ctrl_i.op == OP_ACC_RATE || ctrl_i.op == OP_ACC_SLEW))
      |=> $stable(angle_q))
    else $error("pitch angle changed outside an accumulate step");

endmodule

/* design/orbital_rate_pitch_accumulator_top.sv */
// Top level of the orbital-rate pitch accumulator: configuration, sequencer, datapath, result.
//
// Each accepted tick advances a pitch angle, a binary fraction of one turn, by the orbital
// rate 0.2 deg/s / (k0 + k1 * altitude) times the tick length, at 1x plus a 16x slew in
// operate mode, or by the 256x slew alone in hold mode; every term is rounded to nearest.
// A small control store sequences one shared datapath. For a powered tick the restoring
// divider resolves one quotient bit per cycle, one for each bit of the dividend, and
// seven more steps latch the tick, build the divisor, accumulate and present the result.
// An unpowered tick (body select off or invalid, or a supply missing) runs only the latch,
// multiply and result steps, holds the angle and returns zeros. Ticks are handled one at a
// time; the next tick is accepted as soon as the result is loaded into the output
// register, while that result still waits to be taken. Configuration is written through
// its own channel, which is always ready, and must only be written while idle.
module orbital_rate_pitch_accumulator_top import orpa_pkg::*; #(
  parameter int ANGLE_BITS = 32,
  parameter int TICK_BITS  = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  orpa_cfg_if.sink     cfg_i,
  orpa_tick_if.sink    tick_i,
  orpa_pitch_if.source pitch_o
);

  logic [BODY_BITS-1:0]  body_q;
  logic [ALT_BITS-1:0]   alt_q;
  logic                  out_valid_q, out_valid_d;
  logic [PITCH_BITS-1:0] pitch1_q, pitch2_q;
  logic [PITCH_BITS-1:0] pitch1, pitch2;
  orpa_ctrl_t            ctrl;
  orpa_stat_t            stat;
  logic                  powered, div_more;
  logic                  emit;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_q <= BODY_OFF;
      alt_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_BODY_SELECT: body_q <= cfg_i.data[BODY_BITS-1:0];
        CFG_ALTITUDE:    alt_q  <= cfg_i.data[ALT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tick_i.ready = (ctrl.op == OP_LATCH);

  always_comb begin
    stat.in_valid = tick_i.valid;
    stat.out_free = !out_valid_q || pitch_o.ready;
    stat.powered  = powered;
    stat.div_more = div_more;
  end

  orpa_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  orpa_datapath #(
    .ANGLE_BITS (ANGLE_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .ctrl_i                 (ctrl),
    .body_select_i          (body_q),
    .altitude_setting_i     (alt_q),
    .tick_microseconds_i    (tick_i.tick_microseconds),
    .ac_power_ok_i          (tick_i.ac_power_ok),
    .dc_power_ok_i          (tick_i.dc_power_ok),
    .mode_i                 (tick_i.mode),
    .slew_direction_i       (tick_i.slew_direction),
    .indicator_one_enable_i (tick_i.indicator_one_enable),
    .indicator_two_enable_i (tick_i.indicator_two_enable),
    .powered_o              (powered),
    .div_more_o             (div_more),
    .indicator_one_pitch_o  (pitch1),
    .indicator_two_pitch_o  (pitch2)
  );

  // The emit step only fires when the output register is free or being drained.
  assign emit = ctrl.fire && (ctrl.op == OP_EMIT);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pitch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pitch1_q <= pitch1;
      pitch2_q <= pitch2;
    end
  end

  assign pitch_o.valid               = out_valid_q;
  assign pitch_o.indicator_one_pitch = pitch1_q;
  assign pitch_o.indicator_two_pitch = pitch2_q;

  a_off_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !powered) |=> (pitch1_q == '0 && pitch2_q == '0))
    else $error("unpowered tick produced a nonzero pitch");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i.valid && tick_i.ready) |=> !tick_i.ready)
    else $error("a second tick was taken while one was in work");

endmodule

/* bench/tb_orbital_rate_pitch_accumulator_top.sv */
// Self-checking testbench for the orbital-rate pitch accumulator top level.
`timescale 1ns / 1ps

module tb_orbital_rate_pitch_accumulator_top import orpa_pkg::*; ();

  localparam int ANGLE_W     = 32;
  localparam int TICK_W      = 16;
  localparam int LATENCY     = 70;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 20000;

  // Orbit constants in millionths, and the seconds-to-degrees scale of the drive rate.
  localparam logic [63:0] EARTH_K0_PPM  = 64'd2818200;
  localparam logic [63:0] EARTH_K1_PPM  = 64'd1265;
  localparam logic [63:0] MOON_K0_PPM   = 64'd3584700;
  localparam logic [63:0] MOON_K1_PPM   = 64'd6342;
  localparam logic [63:0] SECONDS_SCALE = 64'd1800;
  localparam logic [63:0] FAST_MULT     = 64'd256;
  localparam logic [63:0] SLOW_MULT     = 64'd16;
  localparam logic [63:0] UNIT_MULT     = 64'd1;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC
  } rx_style_e;

  typedef struct packed {
    logic [TICK_W-1:0] usec;
    logic              ac;
    logic              dc;
    logic              mode;
    logic [1:0]        slew;
    logic              en1;
    logic              en2;
  } tick_beat_t;

  typedef struct packed {
    logic [31:0] one;
    logic [31:0] two;
  } pitch_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  orpa_cfg_if                        cfg_bus ();
  orpa_tick_if #(.TICK_BITS(TICK_W)) tick_bus ();
  orpa_pitch_if                      pitch_bus ();

  orbital_rate_pitch_accumulator_top #(
    .ANGLE_BITS(ANGLE_W),
    .TICK_BITS (TICK_W)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .tick_i (tick_bus),
    .pitch_o(pitch_bus)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the block's state and registers.
  logic [ANGLE_W-1:0] pitch_turns;
  logic [1:0]         body_shadow;
  logic [9:0]         altitude_shadow;

  pitch_beat_t pitch_due_q[$];
  int          fail_count = 0;
  int          cycle_count = 0;

  // Sender pacing and receiver behavior, set per phase.
  int        burst_left = 0;
  int        gap_max = 0;
  rx_style_e rx_style = RX_OPEN;
  int        rx_stall_pct = 0;
  int        rx_cycle = 0;
  bit        rx_hold_req = 1'b0;
  bit        rx_hold_seen = 1'b0;
  int        rx_hold_len = 0;
  int        rx_hold_left = 0;

  // Rounded angle increment for mult times the rate over usec microseconds.
  function automatic logic [63:0] turn_increment(input logic [63:0] mult,
                                                 input logic [TICK_W-1:0] usec,
                                                 input logic [63:0] divisor);
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    num = (mult * {48'd0, usec}) << ANGLE_W;
    quo = num / divisor;
    rem = num - quo * divisor;
    if ((rem << 1) >= divisor) quo = quo + 64'd1;
    return quo;
  endfunction

  function automatic pitch_beat_t advance_pitch(input tick_beat_t b);
    pitch_beat_t        r;
    logic [63:0]        d;
    logic [63:0]        divisor;
    logic [63:0]        inc;
    logic [63:0]        slew_mult;
    logic [ANGLE_W-1:0] a;
    logic               powered;
    r = '0;
    powered = (body_shadow == BODY_EARTH || body_shadow == BODY_MOON) && b.ac && b.dc;
    if (powered) begin
      if (body_shadow == BODY_EARTH) begin
        d = EARTH_K0_PPM + EARTH_K1_PPM * altitude_shadow;
      end else begin
        d = MOON_K0_PPM + MOON_K1_PPM * altitude_shadow;
      end
      divisor = SECONDS_SCALE * d;
      a = pitch_turns;
      slew_mult = (b.mode == MODE_HOLD) ? FAST_MULT : SLOW_MULT;
      // Each term is rounded on its own before it is added.
      if (b.mode != MODE_HOLD) begin
        inc = turn_increment(UNIT_MULT, b.usec, divisor);
        a = a + inc[ANGLE_W-1:0];
      end
      inc = turn_increment(slew_mult, b.usec, divisor);
      if (b.slew == SLEW_UP) begin
        a = a + inc[ANGLE_W-1:0];
      end else if (b.slew == SLEW_DOWN) begin
        a = a - inc[ANGLE_W-1:0];
      end
      pitch_turns = a;
      if (b.en1) r.one = a;
      if (b.en2) r.two = a;
    end
    return r;
  endfunction

  function automatic tick_beat_t make_tick(input logic [TICK_W-1:0] usec, input logic ac,
                                           input logic dc, input logic mode,
                                           input logic [1:0] slew, input logic en1,
                                           input logic en2);
    tick_beat_t b;
    b.usec = usec;
    b.ac   = ac;
    b.dc   = dc;
    b.mode = mode;
    b.slew = slew;
    b.en1  = en1;
    b.en2  = en2;
    return b;
  endfunction

  function automatic tick_beat_t random_tick(input int power_pct);
    tick_beat_t b;
    case ($urandom_range(0, 9))
      0:       b.usec = '0;
      1:       b.usec = '1;
      2, 3:    b.usec = TICK_W'($urandom_range(0, 255));
      default: b.usec = TICK_W'($urandom_range(0, 65535));
    endcase
    b.ac   = ($urandom_range(0, 99) < power_pct);
    b.dc   = ($urandom_range(0, 99) < power_pct);
    b.mode = 1'($urandom_range(0, 1));
    b.slew = 2'($urandom_range(0, 3));
    b.en1  = 1'($urandom_range(0, 1));
    b.en2  = 1'($urandom_range(0, 1));
    return b;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic send_tick(input tick_beat_t beat);
    tick_bus.valid                <= 1'b1;
    tick_bus.tick_microseconds    <= beat.usec;
    tick_bus.ac_power_ok          <= beat.ac;
    tick_bus.dc_power_ok          <= beat.dc;
    tick_bus.mode                 <= beat.mode;
    tick_bus.slew_direction       <= beat.slew;
    tick_bus.indicator_one_enable <= beat.en1;
    tick_bus.indicator_two_enable <= beat.en2;
    do @(posedge clk_i); while (!tick_bus.ready);
    pitch_due_q.push_back(advance_pitch(beat));
  endtask

  // Bursts of back-to-back beats separated by random idle gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        tick_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    tick_bus.valid <= 1'b0;
    while (pitch_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [9:0] data);
    settle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    if (idx == CFG_BODY_SELECT) begin
      body_shadow = data[1:0];
    end else begin
      altitude_shadow = data;
    end
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_paced(input tick_beat_t beat);
    send_tick(beat);
    pace_sender();
  endtask

  // Registers come out of reset with the body select off, so nothing moves.
  task automatic test_reset_state();
    gap_max = 3;
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_UP, 1, 1));
    settle();
  endtask

  task automatic test_earth_sweep();
    write_reg(CFG_BODY_SELECT, {8'd0, BODY_EARTH});
    write_reg(CFG_ALTITUDE, 10'd0);
    // Slewing down from zero wraps below one turn.
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_DOWN, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_NONE, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_HOLD, 2'd3, 1, 1));
    send_paced(make_tick('0, 1, 1, MODE_OPERATE, SLEW_NONE, 1, 1));
    send_paced(make_tick(16'd1, 1, 1, MODE_OPERATE, SLEW_NONE, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_NONE, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_DOWN, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, 2'd3, 1, 1));
    send_paced(make_tick(16'h5A5A, 1, 1, MODE_OPERATE, SLEW_UP, 1, 0));
    send_paced(make_tick(16'hA5A5, 1, 1, MODE_HOLD, SLEW_UP, 0, 1));
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_UP, 0, 0));
    send_paced(make_tick('1, 0, 1, MODE_HOLD, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 0, MODE_HOLD, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 0, 0, MODE_OPERATE, SLEW_DOWN, 1, 1));
    settle();
  endtask

  task automatic test_moon_extremes();
    write_reg(CFG_BODY_SELECT, {8'd0, BODY_MOON});
    write_reg(CFG_ALTITUDE, 10'h3FF);
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_DOWN, 1, 1));
    send_paced(make_tick(16'd1, 1, 1, MODE_OPERATE, SLEW_NONE, 1, 1));
    settle();
  endtask

  // A body select of three reads as off; the upper data bits are ignored.
  task automatic test_invalid_body();
    write_reg(CFG_BODY_SELECT, 10'h3FF);
    send_paced(make_tick('1, 1, 1, MODE_HOLD, SLEW_UP, 1, 1));
    send_paced(make_tick('1, 1, 1, MODE_OPERATE, SLEW_DOWN, 1, 1));
    write_reg(CFG_BODY_SELECT, 10'h3FE);
    write_reg(CFG_ALTITUDE, 10'h155);
    send_paced(make_tick(16'h8001, 1, 1, MODE_OPERATE, SLEW_UP, 1, 1));
    settle();
  endtask

  task automatic test_random_settings();
    logic [9:0] body_data;
    logic [9:0] alt_data;
    int         power_pct;
    for (int phase = 0; phase < 8; phase++) begin
      body_data = 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 4))
        0, 1:    body_data[1:0] = BODY_EARTH;
        2, 3:    body_data[1:0] = BODY_MOON;
        default: ;
      endcase
      case (phase)
        0:       alt_data = 10'd0;
        1:       alt_data = 10'h3FF;
        default: alt_data = 10'($urandom_range(0, 1023));
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_BODY_SELECT, body_data);
        write_reg(CFG_ALTITUDE, alt_data);
      end else begin
        write_reg(CFG_ALTITUDE, alt_data);
        write_reg(CFG_BODY_SELECT, body_data);
      end
      power_pct = (phase == 5) ? 50 : 95;
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 20;
      endcase
      rx_stall_pct = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       rx_style = RX_OPEN;
        1:       rx_style = RX_RANDOM;
        default: rx_style = RX_PERIODIC;
      endcase
      for (int n = 0; n < 115; n++) send_paced(random_tick(power_pct));
      settle();
    end
    rx_style = RX_OPEN;
  endtask

  // The receiver holds off while ticks keep coming, so the block backs up into its input.
  task automatic test_output_backpressure();
    write_reg(CFG_BODY_SELECT, {8'd0, BODY_EARTH});
    write_reg(CFG_ALTITUDE, 10'd200);
    gap_max = 0;
    rx_style = RX_RANDOM;
    rx_stall_pct = 30;
    rx_hold_len = 800;
    rx_hold_req = ~rx_hold_req;
    for (int n = 0; n < 30; n++) send_paced(random_tick(100));
    settle();
  endtask

  // The sender stops mid-stream until every pending result has been taken.
  task automatic test_sender_drain();
    gap_max = 5;
    rx_style = RX_PERIODIC;
    for (int n = 0; n < 20; n++) send_paced(random_tick(100));
    tick_bus.valid <= 1'b0;
    while (pitch_due_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    for (int n = 0; n < 20; n++) send_paced(random_tick(100));
    settle();
    rx_style = RX_OPEN;
  endtask

  // Receiver: a per-phase stall pattern, overridden by an occasional long hold-off.
  initial begin
    pitch_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = rx_hold_len;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pitch_bus.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_RANDOM:   pitch_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
          RX_PERIODIC: pitch_bus.ready <= ((rx_cycle % 11) >= 4);
          default:     pitch_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    pitch_beat_t want;
    if (rst_ni && pitch_bus.valid && pitch_bus.ready) begin
      if (pitch_due_q.size() == 0) begin
        note_failure($sformatf("unexpected result beat: one=%h two=%h",
                               pitch_bus.indicator_one_pitch, pitch_bus.indicator_two_pitch));
      end else begin
        want = pitch_due_q.pop_front();
        if (pitch_bus.indicator_one_pitch !== want.one) begin
          note_failure($sformatf("indicator_one_pitch mismatch: expected %h actual %h",
                                 want.one, pitch_bus.indicator_one_pitch));
        end
        if (pitch_bus.indicator_two_pitch !== want.two) begin
          note_failure($sformatf("indicator_two_pitch mismatch: expected %h actual %h",
                                 want.two, pitch_bus.indicator_two_pitch));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int drain;
    rst_ni                        <= 1'b0;
    cfg_bus.valid                 <= 1'b0;
    cfg_bus.index                 <= CFG_BODY_SELECT;
    cfg_bus.data                  <= '0;
    tick_bus.valid                <= 1'b0;
    tick_bus.tick_microseconds    <= '0;
    tick_bus.ac_power_ok          <= 1'b0;
    tick_bus.dc_power_ok          <= 1'b0;
    tick_bus.mode                 <= MODE_OPERATE;
    tick_bus.slew_direction       <= SLEW_NONE;
    tick_bus.indicator_one_enable <= 1'b0;
    tick_bus.indicator_two_enable <= 1'b0;
    pitch_turns     = '0;
    body_shadow     = BODY_OFF;
    altitude_shadow = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_state();
    test_earth_sweep();
    test_moon_extremes();
    test_invalid_body();
    test_random_settings();
    test_output_backpressure();
    test_sender_drain();

    tick_bus.valid <= 1'b0;
    drain = 0;
    while (pitch_due_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (LATENCY) @(posedge clk_i);
    if (pitch_due_q.size() != 0) begin
      note_failure($sformatf("%0d expected result beats never arrived", pitch_due_q.size()));
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
